// ===== src/frs_pkg.sv =====
// Shared types and constants of the flash request sequencer.
package frs_pkg;

	// Field widths of the request and command transactions.
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned ADDR_W  = 24;
	localparam int unsigned LEN_W   = 25;
	localparam int unsigned OP_W    = 3;
	localparam int unsigned HW_W    = 32;
	localparam int unsigned ST_W    = 3;
	localparam int unsigned CUR_W   = 32;
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// Request command codes.
	localparam logic [CMD_W-1:0] CMD_WRITE       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CHANGE      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ        = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ERASE_ALL   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DRIVER_DONE = 3'd4;

	// Request modes held while a request is in progress.
	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_CHANGE = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_ERASE  = 2'd3;

	// Flash operation codes.
	localparam logic [OP_W-1:0] OP_ERASE_SECTOR = 3'd0;
	localparam logic [OP_W-1:0] OP_ERASE_32K    = 3'd1;
	localparam logic [OP_W-1:0] OP_ERASE_64K    = 3'd2;
	localparam logic [OP_W-1:0] OP_PROGRAM      = 3'd3;
	localparam logic [OP_W-1:0] OP_READ         = 3'd4;
	localparam logic [OP_W-1:0] OP_FINISHED     = 3'd5;

	// Final status codes.
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_ADDR_ERR  = 3'd1;
	localparam logic [ST_W-1:0] ST_DATA_ERR  = 3'd2;
	localparam logic [ST_W-1:0] ST_ERASE_ERR = 3'd3;
	localparam logic [ST_W-1:0] ST_PROG_ERR  = 3'd4;
	localparam logic [ST_W-1:0] ST_READ_ERR  = 3'd5;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_WINDOW_START  = 2'd0;
	localparam logic [1:0] REG_WINDOW_VOLUME = 2'd1;
	localparam logic [1:0] REG_PAGE_LOG2     = 2'd2;
	localparam logic [1:0] REG_SECTOR_LOG2   = 2'd3;

	// Erase block sizes in bytes.
	localparam logic [CUR_W-1:0] BLK64 = 32'h0001_0000;
	localparam logic [CUR_W-1:0] BLK32 = 32'h0000_8000;

	// One request transaction.
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  length;
		logic              driver_ok;
	} req_t;

	// One command transaction.
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [HW_W-1:0]  hw_addr;
		logic [LEN_W-1:0] op_len;
		logic [LEN_W-1:0] buf_offset;
		logic [ST_W-1:0]  status;
	} res_t;

	// Configuration register contents.
	typedef struct packed {
		logic [HW_W-1:0]  window_start;
		logic [LEN_W-1:0] window_volume;
		logic [3:0]       page_size_log2;
		logic [4:0]       sector_size_log2;
	} cfg_t;

	// Input register status toward the sequencing core.
	typedef struct packed {
		logic valid;
		req_t item;
	} stage_t;

endpackage

// ===== src/frs_if.sv =====
// Handshake interfaces for the request and command channels.
interface frs_req_if;
	import frs_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ADDR_W-1:0] addr;
	logic [LEN_W-1:0]  length;
	logic              driver_ok;

	modport source (output valid, output cmd, output addr, output length, output driver_ok,
		input ready);
	modport sink (input valid, input cmd, input addr, input length, input driver_ok,
		output ready);
endinterface

interface frs_cmd_if;
	import frs_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [HW_W-1:0]  hw_addr;
	logic [LEN_W-1:0] op_len;
	logic [LEN_W-1:0] buf_offset;
	logic [ST_W-1:0]  status;

	modport source (output valid, output op, output hw_addr, output op_len, output buf_offset,
		output status, input ready);
	modport sink (input valid, input op, input hw_addr, input op_len, input buf_offset,
		input status, output ready);
endinterface

// ===== src/flash_request_sequencer.sv =====
// Flash request sequencer: turns each request transaction into at most one flash command.
// A request transaction enters the input register when accepted; its command is registered
// when it advances, once the last result is taken. Throughput: one transaction per cycle
// unless the command channel stalls; state is updated in the same cycle as the result.
// Reset: arst_n clears the request state and both valid bits, config returns to defaults.
module flash_request_sequencer #(
	parameter int unsigned ADDR_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [frs_pkg::PADDR_W-1:0] paddr,
	input  logic [frs_pkg::PDATA_W-1:0] pwdata,
	output logic [frs_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	frs_req_if.sink                     request,
	frs_cmd_if.source                   command
);
	import frs_pkg::*;

	cfg_t   cfg;
	req_t   in_item;
	logic   in_ready;
	stage_t stage;
	logic   advance;
	logic   out_valid;
	res_t   out_item;

	// Configuration registers.
	frs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Request channel into the input register.
	assign in_item.cmd       = request.cmd;
	assign in_item.addr      = request.addr;
	assign in_item.length    = request.length;
	assign in_item.driver_ok = request.driver_ok;
	assign request.ready     = in_ready;

	frs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_item  (in_item),
		.in_ready (in_ready),
		.advance  (advance),
		.stage    (stage)
	);

	// Sequencing core with the result register.
	frs_core #(
		.ADDR_BITS (ADDR_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.stage     (stage),
		.advance   (advance),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_ready (command.ready)
	);

	// Command channel from the result register.
	assign command.valid      = out_valid;
	assign command.op         = out_item.op;
	assign command.hw_addr    = out_item.hw_addr;
	assign command.op_len     = out_item.op_len;
	assign command.buf_offset = out_item.buf_offset;
	assign command.status     = out_item.status;

endmodule

// ===== src/frs_cfg_regs.sv =====
// APB configuration registers of the flash request sequencer.
module frs_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [frs_pkg::PADDR_W-1:0]  paddr,
	input  logic [frs_pkg::PDATA_W-1:0]  pwdata,
	output logic [frs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output frs_pkg::cfg_t                cfg
);
	import frs_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_start     <= '0;
			cfg_q.window_volume    <= 25'h100_0000;
			cfg_q.page_size_log2   <= 4'd8;
			cfg_q.sector_size_log2 <= 5'd12;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WINDOW_START:  cfg_q.window_start     <= pwdata;
				REG_WINDOW_VOLUME: cfg_q.window_volume    <= pwdata[LEN_W-1:0];
				REG_PAGE_LOG2:     cfg_q.page_size_log2   <= pwdata[3:0];
				REG_SECTOR_LOG2:   cfg_q.sector_size_log2 <= pwdata[4:0];
			endcase
		end
	end

	// Read data, zero extended.
	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_START:  prdata = cfg_q.window_start;
			REG_WINDOW_VOLUME: prdata = 32'(cfg_q.window_volume);
			REG_PAGE_LOG2:     prdata = 32'(cfg_q.page_size_log2);
			REG_SECTOR_LOG2:   prdata = 32'(cfg_q.sector_size_log2);
		endcase
	end

endmodule

// ===== src/frs_in_stage.sv =====
// Input register that holds one request transaction for the sequencing core.
module frs_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  frs_pkg::req_t  in_item,
	output logic           in_ready,
	input  logic           advance,
	output frs_pkg::stage_t stage
);
	import frs_pkg::*;

	logic valid_s1;
	req_t item_s1;

	// The register frees up whenever its transaction moves on.
	assign in_ready    = !valid_s1 || advance;
	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== src/frs_core.sv =====
// Request state and command generation with the result register.
module frs_core #(
	parameter int unsigned ADDR_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  frs_pkg::cfg_t   cfg,
	input  frs_pkg::stage_t stage,
	output logic            advance,
	output logic            out_valid,
	output frs_pkg::res_t   out_item,
	input  logic            out_ready
);
	import frs_pkg::*;

	localparam logic [32:0] VOL_CAP = 33'd1 << ADDR_BITS;

	// Bytes that fit from the cursor to the end of its page, bounded by what is left.
	function automatic logic [LEN_W-1:0] chunk_len(input logic [CUR_W-1:0] cur,
		input logic [LEN_W-1:0] done, input logic [LEN_W-1:0] rlen, input logic [3:0] psl);
		logic [15:0]      pg;
		logic [15:0]      room;
		logic [LEN_W-1:0] rem;
		pg   = 16'd1 << psl;
		room = pg - (cur[15:0] & (pg - 16'd1));
		rem  = (rlen > done) ? rlen - done : '0;
		return (rem < LEN_W'(room)) ? rem : LEN_W'(room);
	endfunction

	// True when the cursor sits on a sector boundary.
	function automatic logic sector_start(input logic [CUR_W-1:0] cur, input logic [4:0] ssl);
		logic [CUR_W-1:0] mask;
		mask = (32'd1 << ssl) - 32'd1;
		return (cur & mask) == '0;
	endfunction

	// Request state.
	logic             busy_q, busy_d;
	logic [1:0]       req_mode_q, req_mode_d;
	logic [OP_W-1:0]  pending_op_q, pending_op_d;
	logic [CUR_W-1:0] cursor_q, cursor_d;
	logic [LEN_W-1:0] bytes_done_q, bytes_done_d;
	logic [LEN_W-1:0] request_len_q, request_len_d;

	// Result register.
	logic out_valid_s2;
	res_t res_s2;

	// Datapath terms.
	req_t             item;
	logic             is_new;
	logic [LEN_W-1:0] vol;
	logic [15:0]      pg;
	logic [15:0]      change_room;
	logic [LEN_W-1:0] c1;
	logic [CUR_W-1:0] adv_cur;
	logic [LEN_W-1:0] adv_done;
	logic [CUR_W-1:0] step;
	logic [CUR_W-1:0] ecur;
	logic             e_fin;
	logic [LEN_W-1:0] space;
	logic [OP_W-1:0]  e_op;
	logic [CUR_W-1:0] wcur;
	logic [LEN_W-1:0] wdone;
	logic [LEN_W-1:0] wrlen;
	logic [LEN_W-1:0] c2;
	logic             w_sec;

	// Result assembly.
	logic             produce;
	logic             do_erase;
	logic             do_wstart;
	logic             do_prog;
	logic [OP_W-1:0]  r_op;
	logic [LEN_W-1:0] r_len;
	logic [LEN_W-1:0] r_off;
	logic [ST_W-1:0]  r_st;
	logic [CUR_W-1:0] sel_addr;
	res_t             res_d;

	assign item      = stage.item;
	assign advance   = stage.valid && (!out_valid_s2 || out_ready);
	assign out_valid = out_valid_s2;
	assign out_item  = res_s2;

	// Shared address arithmetic.
	always_comb begin
		is_new      = (item.cmd <= CMD_ERASE_ALL);
		vol         = (33'(cfg.window_volume) < VOL_CAP) ? cfg.window_volume
			: VOL_CAP[LEN_W-1:0];
		pg          = 16'd1 << cfg.page_size_log2;
		change_room = pg - (item.addr[15:0] & (pg - 16'd1));

		// Advance after a finished program chunk.
		c1       = chunk_len(cursor_q, bytes_done_q, request_len_q, cfg.page_size_log2);
		adv_cur  = cursor_q + CUR_W'(c1);
		adv_done = bytes_done_q + c1;

		// Next erase block of an erase-all walk.
		unique case (pending_op_q)
			OP_ERASE_64K: step = BLK64;
			OP_ERASE_32K: step = BLK32;
			default:      step = 32'd1 << cfg.sector_size_log2;
		endcase
		ecur  = is_new ? '0 : cursor_q + step;
		e_fin = ecur >= CUR_W'(vol);
		space = vol - ecur[LEN_W-1:0];
		if (cfg.window_start[15:0] == '0 && space >= BLK64[LEN_W-1:0]) begin
			e_op = OP_ERASE_64K;
		end else if (cfg.window_start[14:0] == '0 && space >= BLK32[LEN_W-1:0]) begin
			e_op = OP_ERASE_32K;
		end else begin
			e_op = OP_ERASE_SECTOR;
		end

		// Write chunk position: new request, after a sector erase, or after a program.
		if (is_new) begin
			wcur  = CUR_W'(item.addr);
			wdone = '0;
			wrlen = item.length;
		end else if (pending_op_q == OP_ERASE_SECTOR) begin
			wcur  = cursor_q;
			wdone = bytes_done_q;
			wrlen = request_len_q;
		end else begin
			wcur  = adv_cur;
			wdone = adv_done;
			wrlen = request_len_q;
		end
		c2    = chunk_len(wcur, wdone, wrlen, cfg.page_size_log2);
		w_sec = sector_start(wcur, cfg.sector_size_log2);
	end

	// Decision for the transaction in the input register.
	always_comb begin
		busy_d        = busy_q;
		req_mode_d    = req_mode_q;
		pending_op_d  = pending_op_q;
		cursor_d      = cursor_q;
		bytes_done_d  = bytes_done_q;
		request_len_d = request_len_q;
		produce       = 1'b0;
		do_erase      = 1'b0;
		do_wstart     = 1'b0;
		do_prog       = 1'b0;
		r_op          = OP_FINISHED;
		r_len         = '0;
		r_off         = '0;
		r_st          = ST_OK;
		sel_addr      = '0;

		if (is_new) begin
			// A new request is taken only while no request is in progress.
			if (!busy_q) begin
				produce       = 1'b1;
				busy_d        = 1'b1;
				req_mode_d    = item.cmd[1:0];
				cursor_d      = '0;
				bytes_done_d  = '0;
				request_len_d = '0;
				if (item.cmd == CMD_ERASE_ALL) begin
					do_erase = 1'b1;
				end else if (CUR_W'(item.addr) >= CUR_W'(vol)) begin
					busy_d = 1'b0;
					r_st   = ST_ADDR_ERR;
				end else if (item.length == '0
					|| item.length > vol - LEN_W'(item.addr)) begin
					busy_d = 1'b0;
					r_st   = ST_DATA_ERR;
				end else begin
					cursor_d      = CUR_W'(item.addr);
					request_len_d = item.length;
					if (item.cmd == CMD_WRITE) begin
						do_wstart = 1'b1;
					end else if (item.cmd == CMD_CHANGE) begin
						if (item.length > LEN_W'(change_room)) begin
							busy_d = 1'b0;
							r_st   = ST_DATA_ERR;
						end else begin
							pending_op_d = OP_PROGRAM;
							r_op         = OP_PROGRAM;
							r_len        = item.length;
							sel_addr     = CUR_W'(item.addr);
						end
					end else begin
						pending_op_d = OP_READ;
						r_op         = OP_READ;
						r_len        = item.length;
						sel_addr     = CUR_W'(item.addr);
					end
				end
			end
		end else if (item.cmd == CMD_DRIVER_DONE && busy_q) begin
			produce = 1'b1;
			if (!item.driver_ok) begin
				// Driver failure ends the request with the matching error.
				busy_d = 1'b0;
				if (pending_op_q <= OP_ERASE_64K) begin
					r_st = ST_ERASE_ERR;
				end else if (pending_op_q == OP_PROGRAM) begin
					r_st = ST_PROG_ERR;
				end else begin
					r_st = ST_READ_ERR;
				end
			end else begin
				unique case (req_mode_q)
					MODE_WRITE: begin
						if (pending_op_q == OP_ERASE_SECTOR) begin
							do_prog = 1'b1;
						end else begin
							cursor_d     = adv_cur;
							bytes_done_d = adv_done;
							if (adv_done >= request_len_q || adv_cur >= CUR_W'(vol)) begin
								busy_d = 1'b0;
							end else begin
								do_wstart = 1'b1;
							end
						end
					end
					MODE_ERASE: begin
						do_erase = 1'b1;
					end
					MODE_CHANGE, MODE_READ: begin
						busy_d = 1'b0;
					end
				endcase
			end
		end

		// Next erase block, or the end of the walk.
		if (do_erase) begin
			cursor_d = ecur;
			if (e_fin) begin
				busy_d = 1'b0;
			end else begin
				pending_op_d = e_op;
				r_op         = e_op;
				sel_addr     = ecur;
			end
		end

		// A chunk that starts on a sector boundary erases that sector first.
		if (do_wstart) begin
			if (w_sec) begin
				pending_op_d = OP_ERASE_SECTOR;
				r_op         = OP_ERASE_SECTOR;
				sel_addr     = wcur;
			end else begin
				do_prog = 1'b1;
			end
		end

		// Program one page chunk.
		if (do_prog) begin
			pending_op_d = OP_PROGRAM;
			r_op         = OP_PROGRAM;
			r_len        = c2;
			r_off        = wdone;
			sel_addr     = wcur;
		end

		res_d.op         = r_op;
		res_d.hw_addr    = (r_op == OP_FINISHED) ? '0 : cfg.window_start + sel_addr;
		res_d.op_len     = r_len;
		res_d.buf_offset = r_off;
		res_d.status     = r_st;
	end

	// State and result valid update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			req_mode_q    <= MODE_WRITE;
			pending_op_q  <= OP_ERASE_SECTOR;
			cursor_q      <= '0;
			bytes_done_q  <= '0;
			request_len_q <= '0;
			out_valid_s2  <= 1'b0;
		end else if (advance) begin
			busy_q        <= busy_d;
			req_mode_q    <= req_mode_d;
			pending_op_q  <= pending_op_d;
			cursor_q      <= cursor_d;
			bytes_done_q  <= bytes_done_d;
			request_len_q <= request_len_d;
			out_valid_s2  <= produce;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && produce) begin
			res_s2 <= res_d;
		end
	end

endmodule
